// ===== hw/rtl/swfd_pkg.sv =====
// Package for the sensor word frame decoder.
// Holds status codes, byte phase type, scaling constants and the CRC-8 step.
// No dependencies.
package swfd_pkg;

    typedef enum logic [1:0] {
        ST_MEAS_OK   = 2'd0,
        ST_READY     = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_MSB = 2'd0,
        PH_LSB = 2'd1,
        PH_CRC = 2'd2
    } t_phase;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [15:0] READY_MASK  = 16'h07FF;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] RH_SCALE    = 14'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // One byte through CRC-8, MSB first, no final XOR
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sensor_word_frame_decoder_core.sv =====
// Sensor word frame decoder: CRC-8 check of MSB/LSB/CRC byte triples,
// ready-status and measurement frame decoding with fixed-point scaling.
// Depends on swfd_pkg.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_rx_byte, i_frame_start, i_mode
//  result   out        o_valid / i_ready    o_status, o_co2_ppm, o_temp_centi,
//                                           o_rh_centi
//
// One byte per cycle while the result register is not stalled; a result follows its CRC byte
// transfer through the input register, then the result register.
// The running CRC is updated as each data byte passes, so the CRC byte needs one compare.
// Scaling by 1/65535 is one multiply plus a fold-and-correct step per scaled field.
// Reset closes any open frame and empties both registers.
// A stalled result register holds the input register; o_ready drops only then.
module sensor_word_frame_decoder_core
    import swfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    input  logic               i_mode,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_co2_ppm,
    output logic signed [14:0] o_temp_centi,
    output logic [13:0]        o_rh_centi
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        r_in_mode;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic        r_kind, n_kind;
    logic        r_closed, n_closed;
    logic [7:0]  r_hi, n_hi;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_ws [2];
    logic [15:0] n_ws [2];

    logic        r_out_valid;
    t_status     r_out_status, n_status;
    logic [15:0] r_out_co2, n_co2;
    logic [14:0] r_out_temp, n_temp;
    logic [13:0] r_out_rh, n_rh;
    logic        n_emit;

    logic        adv;
    logic        step;
    t_phase      cur_phase;
    logic        open_frame;
    logic [15:0] word;

    logic [30:0] t_prod;
    logic [16:0] t_fold;
    logic [14:0] t_q;
    logic [29:0] h_prod;
    logic [16:0] h_fold;
    logic [13:0] h_q;

    assign adv        = !r_out_valid || i_ready;
    assign o_ready    = !r_in_valid || adv;
    assign step       = r_in_valid && adv;
    assign cur_phase  = r_in_start ? PH_MSB : r_phase;
    assign open_frame = r_in_start || !r_closed;
    assign word       = {r_hi, r_lo};

    // x / 65535 as (x >> 16) plus one correction on the folded remainder
    assign t_prod = 31'(TEMP_SCALE) * 31'(r_ws[1]);
    assign t_fold = 17'(t_prod[15:0]) + 17'(t_prod[30:16]);
    assign t_q    = t_prod[30:16] + 15'(t_fold >= FULL_SCALE);
    assign h_prod = 30'(RH_SCALE) * 30'(word);
    assign h_fold = 17'(h_prod[15:0]) + 17'(h_prod[29:16]);
    assign h_q    = h_prod[29:16] + 14'(h_fold >= FULL_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
            r_in_mode  <= i_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MSB;
            r_idx    <= 2'd0;
            r_kind   <= 1'b0;
            r_closed <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_kind   <= n_kind;
            r_closed <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_crc <= n_crc;
        r_ws  <= n_ws;
    end

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_kind   = r_kind;
        n_closed = r_closed;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_crc    = r_crc;
        n_ws     = r_ws;
        n_emit   = 1'b0;
        n_status = ST_CRC_ERR;
        n_co2    = 16'd0;
        n_temp   = 15'd0;
        n_rh     = 14'd0;
        if (step) begin
            if (r_in_start) begin
                n_kind   = r_in_mode;
                n_idx    = 2'd0;
                n_phase  = PH_MSB;
                n_closed = 1'b0;
            end
            if (open_frame) begin
                unique case (cur_phase)
                    PH_MSB: begin
                        n_hi    = r_in_byte;
                        n_crc   = crc8_feed(CRC_INIT, r_in_byte);
                        n_phase = PH_LSB;
                    end
                    PH_LSB: begin
                        n_lo    = r_in_byte;
                        n_crc   = crc8_feed(r_crc, r_in_byte);
                        n_phase = PH_CRC;
                    end
                    default: begin
                        n_phase = PH_MSB;
                        if (r_crc != r_in_byte) begin
                            n_closed = 1'b1;
                            n_emit   = 1'b1;
                            n_status = ST_CRC_ERR;
                        end else if (!r_kind) begin
                            n_closed = 1'b1;
                            n_emit   = 1'b1;
                            n_status = ((word & READY_MASK) != 16'd0) ? ST_READY
                                                                      : ST_NOT_READY;
                        end else if (r_idx < 2'd2) begin
                            n_ws[r_idx[0]] = word;
                            n_idx          = r_idx + 2'd1;
                        end else begin
                            n_closed = 1'b1;
                            n_emit   = 1'b1;
                            n_status = ST_MEAS_OK;
                            n_co2    = r_ws[0];
                            n_temp   = t_q - TEMP_OFFSET;
                            n_rh     = h_q;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_status <= n_status;
            r_out_co2    <= n_co2;
            r_out_temp   <= n_temp;
            r_out_rh     <= n_rh;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_co2_ppm    = r_out_co2;
    assign o_temp_centi = $signed(r_out_temp);
    assign o_rh_centi   = r_out_rh;

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_out_valid && !i_ready))
        else $error("input held without a stalled result");

    a_emit_on_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |-> (step && !r_in_start && !r_closed && r_phase == PH_CRC))
        else $error("result raised outside a CRC byte");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |=> r_closed)
        else $error("frame left open after a result");

    a_rh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_MEAS_OK) |-> (r_out_rh <= RH_SCALE))
        else $error("humidity above full scale");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_MEAS_OK) |->
            (r_out_co2 == 16'd0 && r_out_temp == 15'd0 && r_out_rh == 14'd0))
        else $error("non-measurement result carries data");

endmodule
